// ===== sv/fpe_pkg.sv =====
// Shared types, codes and the channel mix function for the framebuffer pixel engine.
// No dependencies; imported by fpe_ctrl, fpe_datapath, framebuffer_pixel_engine and its testbench.
package fpe_pkg;

	localparam int PANEL_WIDTH_DEF  = 64;
	localparam int PANEL_HEIGHT_DEF = 32;
	localparam int COORD_W          = 16;
	localparam int CHAN_W           = 8;
	localparam int CFG_W            = 16;

	// item modes; code 3 writes nothing and returns black
	localparam logic [1:0] MODE_SET   = 2'd0;
	localparam logic [1:0] MODE_BLEND = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// register indexes
	localparam logic REG_CAM_X = 1'b0;
	localparam logic REG_CAM_Y = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MIX,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic rd;
		logic mix;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_status_t;

	// (fresh*a + old*(255-a)) >> 8
	function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] fresh,
			input logic [CHAN_W-1:0] old, input logic [CHAN_W-1:0] a);
		logic [2*CHAN_W-1:0] p_new;
		logic [2*CHAN_W-1:0] p_old;
		logic [2*CHAN_W:0]   sum;
		p_new = (2*CHAN_W)'(fresh) * (2*CHAN_W)'(a);
		p_old = (2*CHAN_W)'(old) * (2*CHAN_W)'(8'd255 - a);
		sum   = {1'b0, p_new} + {1'b0, p_old};
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

// ===== sv/fpe_ctrl.sv =====
// Controller state machine of the framebuffer pixel engine: clearing pass, item sequencing
// and the output word register's valid. Depends on fpe_pkg.
module fpe_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  fpe_pkg::dp_status_t    status,
	output fpe_pkg::ctrl_cmd_t     cmd
);
	import fpe_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold here while the previous word still waits
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase

		if (cmd.commit)
			out_valid_d = 1'b1;
		else if (!out_stall)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sv/fpe_datapath.sv =====
// Datapath of the framebuffer pixel engine: camera registers, clip and address, pixel
// memory, blend and the output word register. Depends on fpe_pkg.
module fpe_datapath #(
	parameter int PANEL_WIDTH  = fpe_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = fpe_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fpe_pkg::ctrl_cmd_t               cmd,
	output fpe_pkg::dp_status_t              status,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_index,
	input  logic [fpe_pkg::CFG_W-1:0]        cfg_data,
	input  logic [1:0]                       mode,
	input  logic signed [fpe_pkg::COORD_W-1:0] world_x,
	input  logic signed [fpe_pkg::COORD_W-1:0] world_y,
	input  logic [fpe_pkg::CHAN_W-1:0]       red_in,
	input  logic [fpe_pkg::CHAN_W-1:0]       green_in,
	input  logic [fpe_pkg::CHAN_W-1:0]       blue_in,
	input  logic [fpe_pkg::CHAN_W-1:0]       alpha,
	output logic [fpe_pkg::CHAN_W-1:0]       red_out,
	output logic [fpe_pkg::CHAN_W-1:0]       green_out,
	output logic [fpe_pkg::CHAN_W-1:0]       blue_out,
	output logic                             inside_res
);
	import fpe_pkg::*;

	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(PANEL_WIDTH);
	localparam int YW    = $clog2(PANEL_HEIGHT);
	localparam int SW    = COORD_W + 1;
	localparam int PW    = 3 * CHAN_W;

	logic [COORD_W-1:0] cam_x_q;
	logic [COORD_W-1:0] cam_y_q;

	logic [1:0]        mode_q;
	logic [SW-1:0]     sx_q;
	logic [SW-1:0]     sy_q;
	logic [PW-1:0]     colour_q;
	logic [CHAN_W-1:0] alpha_q;

	logic              inside_c;
	logic [AW-1:0]     addr_c;
	logic              inside_q;
	logic [AW-1:0]     addr_q;
	logic [PW-1:0]     rdata_q;
	logic [PW-1:0]     mix_q;

	logic [AW-1:0]     clr_cnt_q;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [PW-1:0]     mem_wd;
	logic [PW-1:0]     mem [DEPTH];

	logic [PW-1:0]     out_pix_q;
	logic              inside_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CAM_X: cam_x_q <= cfg_data;
				REG_CAM_Y: cam_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_wr)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	assign status.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	// shifted coordinate at 17 bits, never wraps
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			sx_q     <= {world_x[COORD_W-1], world_x} - {cam_x_q[COORD_W-1], cam_x_q};
			sy_q     <= {world_y[COORD_W-1], world_y} - {cam_y_q[COORD_W-1], cam_y_q};
			colour_q <= {red_in, green_in, blue_in};
			alpha_q  <= alpha;
		end
	end

	assign inside_c = !sx_q[SW-1] && (sx_q < SW'(PANEL_WIDTH))
		&& !sy_q[SW-1] && (sy_q < SW'(PANEL_HEIGHT));
	assign addr_c = AW'(sy_q[YW-1:0]) * AW'(PANEL_WIDTH) + AW'(sx_q[XW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			inside_q <= inside_c;
			addr_q   <= addr_c;
		end
		if (cmd.mix) begin
			mix_q <= {mix_chan(colour_q[PW-1:2*CHAN_W], rdata_q[PW-1:2*CHAN_W], alpha_q),
				mix_chan(colour_q[2*CHAN_W-1:CHAN_W], rdata_q[2*CHAN_W-1:CHAN_W], alpha_q),
				mix_chan(colour_q[CHAN_W-1:0], rdata_q[CHAN_W-1:0], alpha_q)};
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = colour_q;
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end else if (cmd.commit && inside_q) begin
			if (mode_q == MODE_SET) begin
				mem_we = 1'b1;
			end else if (mode_q == MODE_BLEND && alpha_q != '0) begin
				mem_we = 1'b1;
				mem_wd = mix_q;
			end
		end
	end

	// off-panel addresses are read but the data is never used
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (cmd.rd)
			rdata_q <= mem[addr_c];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_pix_q    <= (inside_q && mode_q == MODE_READ) ? rdata_q : '0;
			inside_out_q <= inside_q;
		end
	end

	assign red_out    = out_pix_q[PW-1:2*CHAN_W];
	assign green_out  = out_pix_q[2*CHAN_W-1:CHAN_W];
	assign blue_out   = out_pix_q[CHAN_W-1:0];
	assign inside_res = inside_out_q;

endmodule

// ===== sv/framebuffer_pixel_engine.sv =====
// Top level of the framebuffer pixel engine: joins the controller and the datapath.
// Depends on fpe_pkg, fpe_ctrl and fpe_datapath.
//
//  channel  handshake            word
//  -------  -------------------  ------------------------------------------------
//  in       in_valid / in_stall  mode, world_x, world_y, red_in, green_in,
//                                blue_in, alpha
//  out      out_valid/out_stall  red_out, green_out, blue_out, inside_res
//  cfg      cfg_wr_en            cfg_index, cfg_data
//
// Each word goes through accept, memory read, blend and commit in turn; the pixel memory
// is read before it is written, and no new word is accepted until the commit step.
// After reset every pixel of the memory is cleared, one pixel a cycle, with in_stall
// high; config writes are taken throughout.
// A new word is accepted while the last result waits in the output register; the commit
// step waits only if that result is still stalled.
module framebuffer_pixel_engine #(
	parameter int PANEL_WIDTH  = fpe_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = fpe_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_index,
	input  logic [fpe_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         mode,
	input  logic signed [fpe_pkg::COORD_W-1:0] world_x,
	input  logic signed [fpe_pkg::COORD_W-1:0] world_y,
	input  logic [fpe_pkg::CHAN_W-1:0]         red_in,
	input  logic [fpe_pkg::CHAN_W-1:0]         green_in,
	input  logic [fpe_pkg::CHAN_W-1:0]         blue_in,
	input  logic [fpe_pkg::CHAN_W-1:0]         alpha,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [fpe_pkg::CHAN_W-1:0]         red_out,
	output logic [fpe_pkg::CHAN_W-1:0]         green_out,
	output logic [fpe_pkg::CHAN_W-1:0]         blue_out,
	output logic                               inside_res
);
	import fpe_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	fpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	fpe_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.world_x    (world_x),
		.world_y    (world_y),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.alpha      (alpha),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.inside_res (inside_res)
	);

`ifndef SYNTHESIS
	// one word in flight: busy straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("word accepted while previous one still in flight");

	// a commit never overwrites a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid && out_stall))
		else $error("output word overwritten while stalled");

	// no word accepted during the clearing pass
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> in_stall)
		else $error("input open during memory clear");

	// a taken result leaves the register empty unless a new one lands
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !cmd.commit) |=> !out_valid)
		else $error("output word repeated");
`endif

endmodule

// ===== dv/framebuffer_pixel_engine_tb.sv =====
// Self-checking testbench for framebuffer_pixel_engine: a table of directed words, scored against
// typed results or a local model, then random drawing traffic over several camera offsets, scored by the model.
// Depends on fpe_pkg and the framebuffer_pixel_engine RTL.
module framebuffer_pixel_engine_tb;
	import fpe_pkg::*;

	localparam int PW = PANEL_WIDTH_DEF;
	localparam int PH = PANEL_HEIGHT_DEF;
	localparam logic [1:0] MODE_NONE = 2'd3;	// unused code: no write, black out
	localparam int IDLE_LIMIT = 12000;		// covers the memory clear after reset
	localparam int N_DIRECTED = 25;
	localparam int N_PHASES = 6;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} pixel_op_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       on_panel;
	} pixel_res_t;

	typedef struct packed {
		pixel_op_t  op;
		logic       typed;
		pixel_res_t res;
	} dir_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic               cfg_index = REG_CAM_X;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = MODE_SET;
	logic signed [15:0] world_x = '0;
	logic signed [15:0] world_y = '0;
	logic [7:0]         red_in = '0;
	logic [7:0]         green_in = '0;
	logic [7:0]         blue_in = '0;
	logic [7:0]         alpha = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         red_out;
	logic [7:0]         green_out;
	logic [7:0]         blue_out;
	logic               inside_res;

	// local copy of the panel and the camera
	logic [23:0]        fb_model [PW*PH];
	logic signed [15:0] cam_x = '0;
	logic signed [15:0] cam_y = '0;
	pixel_res_t         pixel_res_q [$];

	int n_fail = 0;
	int n_items = 0;
	int n_results = 0;
	int n_reads_hit = 0;
	int n_blends_hit = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	framebuffer_pixel_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.world_x    (world_x),
		.world_y    (world_y),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.alpha      (alpha),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.inside_res (inside_res)
	);

	function automatic pixel_op_t mk_op(input logic [1:0] md, input int x, input int y,
			input int r, input int g, input int b, input int a);
		pixel_op_t op;
		op = '{md, 16'(x), 16'(y), 8'(r), 8'(g), 8'(b), 8'(a)};
		return op;
	endfunction

	function automatic pixel_res_t mk_res(input int r, input int g, input int b, input bit in);
		pixel_res_t res;
		res = '{8'(r), 8'(g), 8'(b), in};
		return res;
	endfunction

	// updates the local panel and gives the result the block should return
	task automatic apply_pixel_op(input pixel_op_t op, output pixel_res_t res);
		int sx;
		int sy;
		int idx;
		logic [23:0] old;
		int unsigned nr;
		int unsigned ng;
		int unsigned nb;
		sx = int'(op.wx) - int'(cam_x);
		sy = int'(op.wy) - int'(cam_y);
		res = '0;
		res.on_panel = (sx >= 0) && (sx < PW) && (sy >= 0) && (sy < PH);
		if (res.on_panel) begin
			idx = sy * PW + sx;
			old = fb_model[idx];
			case (op.mode)
				MODE_SET: begin
					fb_model[idx] = {op.red, op.green, op.blue};
				end
				MODE_BLEND: begin
					n_blends_hit++;
					if (op.alpha != 8'd0) begin
						nr = (int'(op.red) * int'(op.alpha)
							+ int'(old[23:16]) * (255 - int'(op.alpha))) >> 8;
						ng = (int'(op.green) * int'(op.alpha)
							+ int'(old[15:8]) * (255 - int'(op.alpha))) >> 8;
						nb = (int'(op.blue) * int'(op.alpha)
							+ int'(old[7:0]) * (255 - int'(op.alpha))) >> 8;
						fb_model[idx] = {nr[7:0], ng[7:0], nb[7:0]};
					end
				end
				MODE_READ: begin
					n_reads_hit++;
					{res.red, res.green, res.blue} = old;
				end
				default: ;
			endcase
		end
	endtask

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (tx_quiet || pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pixel_op_t gen_random_op();
		pixel_op_t op;
		int kind;
		int pick;
		int sx;
		int sy;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		op.mode = (pick < 30) ? MODE_SET : (pick < 65) ? MODE_BLEND :
			(pick < 95) ? MODE_READ : MODE_NONE;
		op.red = 8'($urandom_range(0, 255));
		op.green = 8'($urandom_range(0, 255));
		op.blue = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		op.alpha = (pick < 10) ? 8'd0 : (pick < 20) ? 8'd255 : 8'($urandom_range(0, 255));
		if (kind < 80) begin
			// on the panel, often in a small hot patch so that blends and reads hit earlier writes
			sx = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, PW - 1);
			sy = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, PH - 1);
		end else begin
			// over the whole panel and three pixels beyond each edge
			sx = $urandom_range(0, PW + 5) - 3;
			sy = $urandom_range(0, PH + 5) - 3;
		end
		if (kind < 92) begin
			op.wx = 16'(int'(cam_x) + sx);
			op.wy = 16'(int'(cam_y) + sy);
		end else begin
			op.wx = 16'($urandom_range(0, 65535));
			op.wy = 16'($urandom_range(0, 65535));
		end
		return op;
	endfunction

	task automatic hold_in(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		if (pixel_res_q.size() != 0) begin
			in_valid <= 1'b0;
			while (pixel_res_q.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic send_op(input pixel_op_t op, input logic typed, input pixel_res_t typed_res);
		pixel_res_t pred;
		in_valid <= 1'b1;
		mode <= op.mode;
		world_x <= op.wx;
		world_y <= op.wy;
		red_in <= op.red;
		green_in <= op.green;
		blue_in <= op.blue;
		alpha <= op.alpha;
		do @(posedge clk); while (in_stall !== 1'b0);
		apply_pixel_op(op, pred);
		pixel_res_q.push_back(typed ? typed_res : pred);
		n_items++;
	endtask

	// only called with nothing in flight
	task automatic set_camera(input logic signed [15:0] cx, input logic signed [15:0] cy);
		repeat (6) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CAM_X;
		cfg_data <= cx;
		@(posedge clk);
		cfg_index <= REG_CAM_Y;
		cfg_data <= cy;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cam_x = cx;
		cam_y = cy;
	endtask

	// receiver: mostly ready, some short stalls, the odd long one
	always @(posedge clk) begin : rx_side
		int pick;
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_quiet) begin
			out_stall <= 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				out_stall <= 1'b0;
			end else if (pick < 96) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(10, 40);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		pixel_res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pixel_res_q.size() == 0) begin
				$error("result word with no pixel word outstanding");
				n_fail++;
			end else begin
				want = pixel_res_q.pop_front();
				n_results++;
				if (red_out !== want.red) begin
					$error("red_out: expected %0h, got %0h", want.red, red_out);
					n_fail++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0h, got %0h", want.green, green_out);
					n_fail++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0h, got %0h", want.blue, blue_out);
					n_fail++;
				end
				if (inside_res !== want.on_panel) begin
					$error("inside_res: expected %0b, got %0b", want.on_panel, inside_res);
					n_fail++;
				end
			end
		end
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("framebuffer_pixel_engine: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t dir_rows [N_DIRECTED];
		int phase_cx [N_PHASES];
		int phase_cy [N_PHASES];
		int phase_n [N_PHASES];

		foreach (fb_model[i])
			fb_model[i] = '0;

		// camera at reset (0,0); typed rows read straight off the panel state
		dir_rows = '{
			'{mk_op(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_READ, 63, 31, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_READ, 64, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, -1, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 0, 32, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 0, -1, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, -32768, -32768, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 32767, 32767, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_SET, 0, 0, 255, 255, 255, 0), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(255, 255, 255, 1)},
			// zero alpha leaves the pixel alone
			'{mk_op(MODE_BLEND, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(255, 255, 255, 1)},
			'{mk_op(MODE_BLEND, 0, 0, 0, 0, 0, 255), 1'b0, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b0, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_BLEND, 0, 0, 255, 128, 1, 128), 1'b0, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b0, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_SET, 63, 31, 170, 85, 15, 0), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_SET, 64, 31, 18, 52, 86, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_BLEND, 63, -1, 255, 255, 255, 255), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 63, 31, 0, 0, 0, 0), 1'b1, mk_res(170, 85, 15, 1)},
			'{mk_op(MODE_NONE, 5, 5, 255, 255, 255, 255), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_NONE, 32767, -32768, 255, 0, 255, 0), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_READ, 5, 5, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 1)},
			'{mk_op(MODE_SET, 32767, 32767, 255, 255, 255, 255), 1'b1, mk_res(0, 0, 0, 0)},
			'{mk_op(MODE_BLEND, 63, 31, 0, 255, 0, 1), 1'b0, mk_res(0, 0, 0, 0)}
		};

		phase_cx = '{0, -32768, 32767, -5, 0, 17};
		phase_cy = '{0, -32768, 32767, -3, 0, -9};
		phase_n = '{300, 60, 60, 300, 350, 355};
		phase_cx[4] = $urandom_range(0, 40000) - 20000;
		phase_cy[4] = $urandom_range(0, 40000) - 20000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			hold_in(pick_gap());
			send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			set_camera(16'(phase_cx[p]), 16'(phase_cy[p]));
			// last phase opens with a stretch of back-to-back words, no stalls
			tx_quiet = (p == N_PHASES - 1);
			rx_quiet = (p == N_PHASES - 1);
			for (int k = 0; k < phase_n[p]; k++) begin
				if (k == 100) begin
					tx_quiet = 1'b0;
					rx_quiet = 1'b0;
				end
				if ($urandom_range(0, 99) == 0)
					drain_results();
				else
					hold_in(pick_gap());
				send_op(gen_random_op(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("%0d pixel words sent under %0d camera settings, %0d result words checked",
			n_items, N_PHASES, n_results);
		$display("on-panel reads: %0d, on-panel blends: %0d", n_reads_hit, n_blends_hit);
		if (n_fail == 0)
			$display("framebuffer_pixel_engine: match");
		else
			$display("framebuffer_pixel_engine: mismatch");
		$finish;
	end

endmodule
